### rtl/core/text_cursor_glyph_lcd_writer_defines.svh
`ifndef TEXT_CURSOR_GLYPH_LCD_WRITER_DEFINES_SVH
`define TEXT_CURSOR_GLYPH_LCD_WRITER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TCGL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcgl assertion failed");

// next-cycle implication, disabled in reset
`define TCGL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcgl assertion failed");

`endif

### rtl/core/tcgl_pkg.sv
package tcgl_pkg;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_BACKSPACE  = 2'd1,
    OP_SET_CURSOR = 2'd2,
    OP_WRITE_AT   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] char_code;
    logic [3:0] cursor_col;
    logic [1:0] cursor_row;
    logic [2:0] page;
    logic [6:0] column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] glyph;
    logic [2:0] page;
    logic [6:0] column;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } glyph_hit_t;

  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [7:0] CMD_COL_LOW  = 8'h00;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  localparam logic [3:0] GLYPH_STAR  = 4'd10;
  localparam logic [3:0] GLYPH_HASH  = 4'd11;
  localparam logic [3:0] GLYPH_SPACE = 4'd12;
  localparam logic [3:0] GLYPH_DOT   = 4'd13;

  localparam logic [3:0] LAST_COL = 4'd15;

  // beat positions inside one 22-beat run
  localparam logic [4:0] CMD_LEN  = 5'd3;
  localparam logic [4:0] HALF_LEN = 5'd11;
  localparam logic [4:0] RUN_LEN  = 5'd22;

  localparam logic [7:0] GLYPH_ROM [224] = '{
    8'h00,8'h00,8'hE0,8'h0F,8'h10,8'h10,8'h08,8'h20,
    8'h08,8'h20,8'h10,8'h10,8'hE0,8'h0F,8'h00,8'h00,
    8'h00,8'h00,8'h10,8'h20,8'h10,8'h20,8'hF8,8'h3F,
    8'h00,8'h20,8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h70,8'h30,8'h08,8'h28,8'h08,8'h24,
    8'h08,8'h22,8'h88,8'h21,8'h70,8'h30,8'h00,8'h00,
    8'h00,8'h00,8'h30,8'h18,8'h08,8'h20,8'h88,8'h20,
    8'h88,8'h20,8'h48,8'h11,8'h30,8'h0E,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h07,8'hC0,8'h04,8'h20,8'h24,
    8'h10,8'h24,8'hF8,8'h3F,8'h00,8'h24,8'h00,8'h00,
    8'h00,8'h00,8'hF8,8'h19,8'h08,8'h21,8'h88,8'h20,
    8'h88,8'h20,8'h08,8'h11,8'h08,8'h0E,8'h00,8'h00,
    8'h00,8'h00,8'hE0,8'h0F,8'h10,8'h11,8'h88,8'h20,
    8'h88,8'h20,8'h18,8'h11,8'h00,8'h0E,8'h00,8'h00,
    8'h00,8'h00,8'h38,8'h00,8'h08,8'h00,8'h08,8'h3F,
    8'hC8,8'h00,8'h38,8'h00,8'h08,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h70,8'h1C,8'h88,8'h22,8'h08,8'h21,
    8'h08,8'h21,8'h88,8'h22,8'h70,8'h1C,8'h00,8'h00,
    8'h00,8'h00,8'hE0,8'h00,8'h10,8'h31,8'h08,8'h22,
    8'h08,8'h22,8'h10,8'h11,8'hE0,8'h0F,8'h00,8'h00,
    8'h40,8'h02,8'h40,8'h02,8'h80,8'h01,8'hF0,8'h0F,
    8'h80,8'h01,8'h40,8'h02,8'h40,8'h02,8'h00,8'h00,
    8'h40,8'h04,8'hC0,8'h3F,8'h78,8'h04,8'h40,8'h04,
    8'hC0,8'h3F,8'h78,8'h04,8'h40,8'h04,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h30,8'h00,8'h30,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  function automatic glyph_hit_t glyph_lookup(input logic [7:0] code);
    glyph_hit_t r;
    logic [7:0] diff;
    diff  = code - CHAR_ZERO;
    r.hit = 1'b1;
    r.idx = diff[3:0];
    case (code) inside
      [CHAR_ZERO:CHAR_NINE]: r.idx = diff[3:0];
      CHAR_STAR:             r.idx = GLYPH_STAR;
      CHAR_HASH:             r.idx = GLYPH_HASH;
      CHAR_SPACE:            r.idx = GLYPH_SPACE;
      CHAR_DOT:              r.idx = GLYPH_DOT;
      default: begin
        r.hit = 1'b0;
        r.idx = '0;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/core/tcgl_front.sv
module tcgl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcgl_pkg::in_item_t in_item,
  input  logic               full,
  output logic               push,
  output tcgl_pkg::job_t     push_job
);
  import tcgl_pkg::*;

  logic [3:0] text_col, text_col_next;
  logic [1:0] text_row, text_row_next;
  logic [3:0] bs_col;
  logic [1:0] bs_row;
  logic       accept;
  logic       draw;
  glyph_hit_t hit;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push     = accept && draw;
  assign hit      = glyph_lookup(in_item.char_code);

  always_comb begin
    bs_col = text_col;
    bs_row = text_row;
    if (text_col != '0) begin
      bs_col = text_col - 4'd1;
    end else if (text_row != '0) begin
      bs_col = LAST_COL;
      bs_row = text_row - 2'd1;
    end
  end

  always_comb begin
    text_col_next   = text_col;
    text_row_next   = text_row;
    draw            = 1'b0;
    push_job.glyph  = hit.idx;
    push_job.page   = {text_row, 1'b0};
    push_job.column = {text_col, 3'b000};
    case (in_item.operation)
      OP_WRITE: begin
        draw          = hit.hit;
        text_col_next = text_col + 4'd1;
        if (text_col == LAST_COL) begin
          text_row_next = text_row + 2'd1;
        end
      end
      OP_BACKSPACE: begin
        draw            = 1'b1;
        text_col_next   = bs_col;
        text_row_next   = bs_row;
        push_job.glyph  = GLYPH_SPACE;
        push_job.page   = {bs_row, 1'b0};
        push_job.column = {bs_col, 3'b000};
      end
      OP_SET_CURSOR: begin
        text_col_next = in_item.cursor_col;
        text_row_next = in_item.cursor_row;
      end
      OP_WRITE_AT: begin
        draw            = hit.hit;
        push_job.page   = in_item.page;
        push_job.column = in_item.column;
      end
      default: begin
        draw = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_col <= '0;
      text_row <= '0;
    end else if (accept) begin
      text_col <= text_col_next;
      text_row <= text_row_next;
    end
  end

endmodule

### rtl/core/tcgl_queue.sv
module tcgl_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcgl_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tcgl_pkg::job_t head_job,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import tcgl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/core/tcgl_back.sv
module tcgl_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  tcgl_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tcgl_pkg::out_item_t out_item
);
  import tcgl_pkg::*;

  logic [4:0] beat;
  logic       advance;
  logic       last_beat;
  logic [4:0] off;
  logic [3:0] rom_k;
  out_item_t  item_next;

  assign advance   = head_valid && (!out_valid || !out_stall);
  assign last_beat = beat == RUN_LEN - 5'd1;
  assign pop       = advance && last_beat;

  always_comb begin
    off   = beat - CMD_LEN;
    rom_k = {off[2:0], 1'b0};
    if (beat >= HALF_LEN) begin
      off   = beat - HALF_LEN - CMD_LEN;
      rom_k = {off[2:0], 1'b1};
    end
  end

  always_comb begin
    item_next.last    = last_beat;
    item_next.is_data = 1'b1;
    item_next.out_byte = GLYPH_ROM[{head_job.glyph, rom_k}];
    case (beat) inside
      5'd0: begin
        item_next.is_data  = 1'b0;
        item_next.out_byte = CMD_PAGE + 8'(head_job.page);
      end
      HALF_LEN: begin
        item_next.is_data  = 1'b0;
        item_next.out_byte = CMD_PAGE + 8'(head_job.page) + 8'd1;
      end
      5'd1, HALF_LEN + 5'd1: begin
        item_next.is_data  = 1'b0;
        item_next.out_byte = CMD_COL_HIGH + 8'(head_job.column[6:4]);
      end
      5'd2, HALF_LEN + 5'd2: begin
        item_next.is_data  = 1'b0;
        item_next.out_byte = CMD_COL_LOW + 8'(head_job.column[3:0]);
      end
      default: begin
        item_next.is_data = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        beat      <= last_beat ? '0 : beat + 5'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/text_cursor_glyph_lcd_writer.sv
// Text writer for a page-addressed monochrome LCD: each in beat is one text operation,
// each out beat one controller byte (is_data drives A0). A drawn character gives 22
// beats, one per cycle from the byte sequencer while out_stall is low; set-cursor and
// unsupported characters give no out beats. The decoder updates the 16x4 cursor at
// accept and hands glyph jobs to the sequencer through a QUEUE_DEPTH-entry queue;
// in_stall is high while it is full.
module text_cursor_glyph_lcd_writer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcgl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tcgl_pkg::out_item_t out_item
);
  import tcgl_pkg::*;
  `include "text_cursor_glyph_lcd_writer_defines.svh"

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic          push;
  job_t          push_job;
  logic          full;
  logic          pop;
  logic          head_valid;
  job_t          head_job;
  logic [CW-1:0] count;

  tcgl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  tcgl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .count      (count)
  );

  tcgl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  `TCGL_ASSERT_NOW(a_last_is_data, clk, rst, out_valid && out_item.last, out_item.is_data)
  `TCGL_ASSERT_NOW(a_no_push_when_full, clk, rst, full, !push)
  `TCGL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `TCGL_ASSERT_NEXT(a_pop_then_cmd, clk, rst, pop, !head_valid || !out_valid || out_item.last)

endmodule
